// File: hw/rtl/contiguous_page_window_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous page window allocator
// Shared property forms: same-cycle and next-cycle implication under reset.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_WINDOW_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_WINDOW_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CPWA_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("cpwa: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CPWA_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("cpwa: next-cycle check failed");

`endif

// File: hw/rtl/cpwa_pkg.sv
// ---------------------------------------------------------------------------
// cpwa_pkg
// Types, field widths and codes shared by the page window allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpwa_pkg;

	// default geometry
	localparam int DEF_WINDOW_PAGES = 1024;
	localparam int DEF_PAGE_SHIFT   = 12;

	// transaction field widths
	localparam int ADDR_W       = 32;
	localparam int LEN_W        = 23;
	localparam int STATUS_W     = 2;
	localparam int FIRST_PAGE_W = 10;
	localparam int PAGE_COUNT_W = 11;

	// bitmap word geometry
	localparam int WORD_BITS = 16;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int RUN_W     = $clog2(WORD_BITS + 1);

	// offset + length + rounding never exceeds this width
	localparam int SUM_W = 25;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_WINDOW_BASE = 1'b0;

	// commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_RUN  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

	typedef struct packed {
		logic                    cmd;
		logic [ADDR_W-1:0]       phys_addr;
		logic [LEN_W-1:0]        length;
		logic [ADDR_W-1:0]       virt_addr;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [ADDR_W-1:0]       granted_virt;
		logic [LEN_W-1:0]        granted_len;
		logic [FIRST_PAGE_W-1:0] first_page;
		logic [PAGE_COUNT_W-1:0] page_count;
	} rsp_t;

endpackage

// File: hw/rtl/contiguous_page_window_allocator.sv
// ---------------------------------------------------------------------------
// contiguous_page_window_allocator
// First-fit allocator of page runs inside a virtual mapping window, with the
// page-used bitmap kept in a word RAM and scanned one word per cycle.
// ---------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   cpwa_pkg::req_t
//  rsp      out        rsp_valid / rsp_stall   cpwa_pkg::rsp_t
//  apb      in         psel / penable / pready window_base at byte 0
//
//  Allocate: set-up in PREP and CHECK, then one cycle per bitmap word up to the word
//  where the run ends (at most ceil(WINDOW_PAGES/16), 64 by default), then
//  MARK_RD and one cycle per word the run covers, read-modify-write on the RAM port.
//  Free: PREP, CHECK, MARK_RD, then one cycle per word the run covers.
//  Reset clears the row valid flags at once; no clearing pass is needed.
//  One request is in flight; a finished result waits in the output register
//  while the next request is taken, and holds the engine only if still stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "contiguous_page_window_allocator_macros.svh"

module contiguous_page_window_allocator #(
	parameter int WINDOW_PAGES = cpwa_pkg::DEF_WINDOW_PAGES,
	parameter int PAGE_SHIFT   = cpwa_pkg::DEF_PAGE_SHIFT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpwa_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cpwa_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cpwa_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  cpwa_pkg::req_t                  req,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output cpwa_pkg::rsp_t                  rsp
);
	import cpwa_pkg::*;

	localparam int NWORDS    = (WINDOW_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IDX_W     = WA_W + BIT_W;
	localparam int CNT_W     = $clog2(WINDOW_PAGES + 1);
	localparam int TOT_W     = CNT_W + 1;
	localparam int NF_W      = SUM_W - PAGE_SHIFT;
	localparam int S_W       = ADDR_W - PAGE_SHIFT;
	localparam int PF_LEVELS = BIT_W;
	localparam logic [ADDR_W-1:0] OFF_MASK  = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [ADDR_W-1:0] WIN_PAGES = ADDR_W'(WINDOW_PAGES);
	localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(NWORDS - 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PREP    = 3'd1;
	localparam logic [2:0] S_CHECK   = 3'd2;
	localparam logic [2:0] S_SCAN    = 3'd3;
	localparam logic [2:0] S_MARK_RD = 3'd4;
	localparam logic [2:0] S_MARK_WR = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0]            state_q;
	logic [ADDR_W-1:0]     base_q;
	req_t                  req_q;
	logic [NF_W-1:0]       nfull_q;
	logic [S_W-1:0]        s_full_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      carry_q;
	logic [WA_W-1:0]       word_q;
	logic [WA_W-1:0]       mark_word_q;
	logic [IDX_W-1:0]      lo_q;
	logic [IDX_W-1:0]      hi_q;
	rsp_t                  res_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                  cfg_wr;
	logic                  rsp_free;
	logic [PAGE_SHIFT-1:0] off;
	logic [SUM_W-1:0]      span_sum;
	logic [NF_W-1:0]       nf_raw;
	logic [NF_W-1:0]       nfull_d;
	logic [ADDR_W-1:0]     rel;
	logic                  alloc_fits;
	logic                  free_fits;

	logic                  mem_rd_en;
	logic [WA_W-1:0]       mem_rd_addr;
	logic [WORD_BITS-1:0]  mem_rd_data;
	logic                  mem_wr_en;
	logic [WA_W-1:0]       mem_wr_addr;
	logic [WORD_BITS-1:0]  mem_wr_data;

	logic [WORD_BITS-1:0]  eff;
	logic [WORD_BITS-1:0]  a_v;
	logic [WORD_BITS-1:0]  a_n;
	logic [RUN_W-1:0]      l_v [WORD_BITS];
	logic [RUN_W-1:0]      l_n [WORD_BITS];
	logic [TOT_W-1:0]      total [WORD_BITS];
	logic [WORD_BITS-1:0]  hit;
	logic [BIT_W-1:0]      hit_bit;
	logic [IDX_W-1:0]      end_idx;
	logic [IDX_W-1:0]      start_idx;

	logic [WA_W-1:0]       lo_word;
	logic [WA_W-1:0]       hi_word;
	logic [BIT_W-1:0]      lo_bit;
	logic [BIT_W-1:0]      hi_bit;
	logic [WORD_BITS-1:0]  run_mask;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_WINDOW_BASE);
	assign prdata = (paddr[APB_ADDR_W-1] == REG_WINDOW_BASE) ? base_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr) begin
			base_q <= pwdata;
		end
	end

	// handshakes
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// run length and window-relative page of the latched request
	assign off      = req_q.phys_addr[PAGE_SHIFT-1:0];
	assign span_sum = SUM_W'(off) + SUM_W'(req_q.length) + SUM_W'(OFF_MASK);
	assign nf_raw   = span_sum[SUM_W-1:PAGE_SHIFT];
	assign nfull_d  = (nf_raw == '0) ? NF_W'(1) : nf_raw;
	assign rel      = req_q.virt_addr - ADDR_W'(off) - base_q;

	assign alloc_fits = (ADDR_W'(nfull_q) <= WIN_PAGES);
	assign free_fits  = (ADDR_W'(s_full_q) < WIN_PAGES) &&
		(ADDR_W'(s_full_q) + ADDR_W'(nfull_q) <= WIN_PAGES);

	// word evaluation: free runs ending at each bit, carried in from below
	always_comb begin
		for (int k = 0; k < WORD_BITS; k++) begin
			eff[k] = mem_rd_data[k] ||
				(ADDR_W'({word_q, BIT_W'(k)}) >= WIN_PAGES);
		end
		a_v = ~eff;
		for (int k = 0; k < WORD_BITS; k++) begin
			l_v[k] = RUN_W'(a_v[k]);
		end
		// prefix over doubling spans
		for (int lv = 0; lv < PF_LEVELS; lv++) begin
			for (int k = 0; k < WORD_BITS; k++) begin
				if (k >= (1 << lv)) begin
					a_n[k] = a_v[k] && a_v[k - (1 << lv)];
					l_n[k] = a_v[k] ? l_v[k] + l_v[k - (1 << lv)] : l_v[k];
				end else begin
					a_n[k] = a_v[k];
					l_n[k] = l_v[k];
				end
			end
			a_v = a_n;
			l_v = l_n;
		end
		for (int k = 0; k < WORD_BITS; k++) begin
			total[k] = a_v[k] ? TOT_W'(carry_q) + TOT_W'(l_v[k]) : TOT_W'(l_v[k]);
			hit[k]   = (total[k] >= TOT_W'(n_q));
		end
		// lowest bit where the run first reaches its length
		hit_bit = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				hit_bit = BIT_W'(k);
			end
		end
	end

	assign end_idx   = {word_q, hit_bit};
	assign start_idx = IDX_W'(ADDR_W'(end_idx) + ADDR_W'(1) - ADDR_W'(n_q));

	// bit mask of the run within the word being rewritten
	assign lo_word  = lo_q[IDX_W-1:BIT_W];
	assign hi_word  = hi_q[IDX_W-1:BIT_W];
	assign lo_bit   = (mark_word_q == lo_word) ? lo_q[BIT_W-1:0] : '0;
	assign hi_bit   = (mark_word_q == hi_word) ? hi_q[BIT_W-1:0] : '1;
	assign run_mask = ({WORD_BITS{1'b1}} << lo_bit) &
		({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));

	// bitmap RAM accesses
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = mark_word_q;
		mem_wr_data = (req_q.cmd == CMD_ALLOC) ? (mem_rd_data | run_mask) :
			(mem_rd_data & ~run_mask);
		unique case (state_q)
			S_CHECK: begin
				mem_rd_en = (req_q.cmd == CMD_ALLOC) && alloc_fits;
			end
			S_SCAN: begin
				mem_rd_en   = (hit == '0) && (word_q != LAST_WORD);
				mem_rd_addr = word_q + WA_W'(1);
			end
			S_MARK_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = lo_word;
			end
			S_MARK_WR: begin
				mem_wr_en   = 1'b1;
				mem_rd_en   = (mark_word_q != hi_word);
				mem_rd_addr = mark_word_q + WA_W'(1);
			end
			default: begin
			end
		endcase
	end

	cpwa_bitmap #(
		.NWORDS (NWORDS),
		.WA_W   (WA_W)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// request datapath registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		if (state_q == S_PREP) begin
			nfull_q  <= nfull_d;
			s_full_q <= rel[ADDR_W-1:PAGE_SHIFT];
		end
		if (state_q == S_CHECK) begin
			n_q     <= CNT_W'(nfull_q);
			carry_q <= '0;
			word_q  <= '0;
			lo_q    <= IDX_W'(s_full_q);
			hi_q    <= IDX_W'(ADDR_W'(s_full_q) + ADDR_W'(nfull_q) - ADDR_W'(1));
			// failure answer until a run is marked
			res_q   <= '{status: (req_q.cmd == CMD_ALLOC) ? ST_NO_RUN : ST_OUTSIDE,
				default: '0};
		end
		if (state_q == S_SCAN) begin
			if (hit != '0) begin
				lo_q <= start_idx;
				hi_q <= end_idx;
			end else begin
				carry_q <= CNT_W'(total[WORD_BITS-1]);
				word_q  <= word_q + WA_W'(1);
			end
		end
		if (state_q == S_MARK_RD) begin
			mark_word_q       <= lo_word;
			res_q.status      <= ST_OK;
			res_q.first_page  <= FIRST_PAGE_W'(lo_q);
			res_q.page_count  <= PAGE_COUNT_W'(n_q);
			if (req_q.cmd == CMD_ALLOC) begin
				res_q.granted_virt <= base_q + (ADDR_W'(lo_q) << PAGE_SHIFT) + ADDR_W'(off);
				res_q.granted_len  <= LEN_W'((ADDR_W'(n_q) << PAGE_SHIFT) - ADDR_W'(off));
			end else begin
				res_q.granted_virt <= '0;
				res_q.granted_len  <= '0;
			end
		end
		if (state_q == S_MARK_WR) begin
			mark_word_q <= mark_word_q + WA_W'(1);
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (req_q.cmd == CMD_ALLOC) begin
						state_q <= alloc_fits ? S_SCAN : S_DONE;
					end else begin
						state_q <= free_fits ? S_MARK_RD : S_DONE;
					end
				end
				S_SCAN: begin
					if (hit != '0) begin
						state_q <= S_MARK_RD;
					end else if (word_q == LAST_WORD) begin
						state_q <= S_DONE;
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (mark_word_q == hi_word) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// checks
	`CPWA_ASSERT_NOW(a_scan_short, clk, arst_n, state_q == S_SCAN, carry_q < n_q)
	`CPWA_ASSERT_NOW(a_ram_no_overlap, clk, arst_n, mem_rd_en && mem_wr_en,
		mem_rd_addr != mem_wr_addr)
	`CPWA_ASSERT_NOW(a_mark_in_run, clk, arst_n, state_q == S_MARK_WR,
		(mark_word_q >= lo_word) && (mark_word_q <= hi_word))
	`CPWA_ASSERT_NOW(a_fail_zero, clk, arst_n, rsp_valid_q && rsp_q.status != ST_OK,
		(rsp_q.page_count == '0) && (rsp_q.granted_virt == '0))
	`CPWA_ASSERT_NEXT(a_no_repeat, clk, arst_n,
		rsp_valid_q && !rsp_stall && state_q != S_DONE, !rsp_valid_q)

endmodule

// File: hw/rtl/cpwa_bitmap.sv
// ---------------------------------------------------------------------------
// cpwa_bitmap
// Page-used bitmap held as words in a synchronous RAM, registered read.
// Each row has a valid flag cleared by reset; an unwritten row reads as free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpwa_bitmap #(
	parameter int NWORDS = 64,
	parameter int WA_W   = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [WA_W-1:0]                rd_addr,
	output logic [cpwa_pkg::WORD_BITS-1:0] rd_data,
	input  logic                           wr_en,
	input  logic [WA_W-1:0]                wr_addr,
	input  logic [cpwa_pkg::WORD_BITS-1:0] wr_data
);
	import cpwa_pkg::*;

	logic [WORD_BITS-1:0] mem [NWORDS];
	logic [NWORDS-1:0]    row_valid_q;
	logic [WORD_BITS-1:0] rd_word_s1;
	logic                 rd_valid_s1;

	// storage array, read and write ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	// row valid flags, all rows free after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_word_s1 : '0;

endmodule

// File: tb/contiguous_page_window_allocator_tb.sv
// ---------------------------------------------------------------------------
// contiguous_page_window_allocator_tb
// Self-checking bench for the page window allocator. Allocate and free
// transactions are planned against a bit-level page map, driven with random
// gaps, and each result is checked field by field against the outcome
// predicted at acceptance. The window base is reprogrammed between phases,
// including the lowest and highest page-aligned bases and one drawn without alignment.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_page_window_allocator_tb;
	import cpwa_pkg::*;

	localparam int          WIN           = DEF_WINDOW_PAGES;
	localparam int          PAGE_SHIFT    = DEF_PAGE_SHIFT;
	localparam int unsigned PAGE_BYTES    = 1 << PAGE_SHIFT;
	localparam int          CLK_HALF      = 10;
	localparam int          DRAIN_CYCLES  = 200;
	localparam int          PRESSURE_STEP = 400;
	localparam int          LONG_HOLD     = 500;
	localparam logic [APB_ADDR_W-1:0] WINDOW_BASE_ADDR = {REG_WINDOW_BASE, 2'b00};

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;

	// bench state
	req_t        pending_requests[$];
	rsp_t        expected_outcomes[$];
	req_t        live_grants[$];
	bit [WIN-1:0] live_map;
	bit [WIN-1:0] plan_map;
	logic [31:0] window_base_model;
	bit          quiet;
	int          gap_left;
	int          hold_left;
	int          long_holds;
	int          results_seen;
	int          mismatch_count;

	contiguous_page_window_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Outcome of one transaction; updates the chosen page map as the block would
	function automatic rsp_t page_run_outcome(input req_t r, input bit planning);
		bit [WIN-1:0] map;
		int unsigned  off, n, s, run_len, i, k;
		logic [31:0]  vbase, rel;
		bit           found;
		rsp_t         o;
		map = planning ? plan_map : live_map;
		o = '0;
		off = r.phys_addr & (PAGE_BYTES - 1);
		n = (off + r.length + PAGE_BYTES - 1) >> PAGE_SHIFT;
		if (n == 0)
			n = 1;
		if (r.cmd == CMD_ALLOC) begin
			// first fit: lowest run of n free pages
			o.status = ST_NO_RUN;
			found = 1'b0;
			run_len = 0;
			s = 0;
			if (n <= WIN) begin
				for (i = 0; i < WIN && !found; i++) begin
					run_len = map[i] ? 0 : run_len + 1;
					if (run_len == n) begin
						found = 1'b1;
						s = i + 1 - n;
						for (k = s; k <= i; k++)
							map[k] = 1'b1;
					end
				end
			end
			if (found) begin
				o.status       = ST_OK;
				o.granted_virt = window_base_model + (s << PAGE_SHIFT) + off;
				o.granted_len  = LEN_W'(n * PAGE_BYTES - off);
				o.first_page   = FIRST_PAGE_W'(s);
				o.page_count   = PAGE_COUNT_W'(n);
			end
		end else begin
			// free: locate run from the virtual address, wrapping mod 2^32
			vbase = r.virt_addr - off;
			rel = vbase - window_base_model;
			s = rel >> PAGE_SHIFT;
			if (s >= WIN || n > WIN - s) begin
				o.status = ST_OUTSIDE;
			end else begin
				for (i = 0; i < n; i++)
					map[s + i] = 1'b0;
				o.status     = ST_OK;
				o.first_page = FIRST_PAGE_W'(s);
				o.page_count = PAGE_COUNT_W'(n);
			end
		end
		if (planning)
			plan_map = map;
		else
			live_map = map;
		return o;
	endfunction

	// Mostly short idles, occasionally a long one
	function automatic int idle_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 0;
		else if (sel < 85)
			return $urandom_range(1, 3);
		else if (sel < 97)
			return $urandom_range(4, 15);
		else
			return $urandom_range(30, 80);
	endfunction

	// Byte lengths: mostly a few pages, some large, the odd full-width one
	function automatic logic [LEN_W-1:0] region_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return LEN_W'($urandom_range(0, 32'h4000));
		else if (sel < 90)
			return LEN_W'($urandom_range(0, 32'h3FFFF));
		else if (sel < 97)
			return LEN_W'($urandom_range(0, 32'h3FFFFF));
		else
			return 23'h400000;
	endfunction

	// Queue a transaction and keep the planning map in step
	task automatic issue(input req_t r, output rsp_t o);
		o = page_run_outcome(r, 1'b1);
		pending_requests.push_back(r);
	endtask

	task automatic issue_fields(input logic cmd, input logic [31:0] phys,
		input logic [LEN_W-1:0] len, input logic [31:0] virt);
		req_t r;
		rsp_t o;
		r.cmd       = cmd;
		r.phys_addr = phys;
		r.length    = len;
		r.virt_addr = virt;
		issue(r, o);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_outcomes.size() != 0);
	endtask

	// APB write of the window base, then read it back
	task automatic write_window_base(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WINDOW_BASE_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(negedge clk);
		while (!pready);
		@(posedge clk);
		window_base_model = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(negedge clk);
		while (!pready);
		if (prdata !== window_base_model) begin
			$error("window_base: expected %h, got %h", window_base_model, prdata);
			mismatch_count++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// New base; start from an empty window, then random traffic
	task automatic run_phase(input logic [31:0] base, input int count, input bit calm);
		req_t r;
		rsp_t o;
		int   sel, idx, j;
		wait_idle();
		write_window_base(base);
		quiet = calm;
		plan_map = live_map;
		live_grants.delete();
		issue_fields(CMD_FREE, 32'h0, 23'h400000, base);
		issue_fields(CMD_FREE, 32'h0, 23'h0, base - PAGE_BYTES);
		for (j = 0; j < count; j++) begin
			sel = $urandom_range(0, 99);
			if ((sel < 35 && live_grants.size() > 0) || live_grants.size() > 48) begin
				// well-formed release of an earlier grant
				idx = $urandom_range(0, live_grants.size() - 1);
				r = live_grants[idx];
				live_grants.delete(idx);
			end else if (sel < 90) begin
				r.cmd       = CMD_ALLOC;
				r.phys_addr = $urandom;
				r.length    = region_length();
				r.virt_addr = $urandom;
			end else begin
				// stray free: random address, or a random page of the window
				r.cmd       = CMD_FREE;
				r.phys_addr = $urandom;
				r.length    = region_length();
				if ($urandom_range(0, 1))
					r.virt_addr = $urandom;
				else
					r.virt_addr = base + ($urandom_range(0, WIN - 1) << PAGE_SHIFT)
						+ (r.phys_addr & (PAGE_BYTES - 1));
			end
			issue(r, o);
			if (r.cmd == CMD_ALLOC && o.status == ST_OK) begin
				r.cmd       = CMD_FREE;
				r.virt_addr = o.granted_virt;
				live_grants.push_back(r);
			end
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left  <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_outcomes.push_back(page_run_outcome(req, 1'b0));
			if (req_valid && req_stall) begin
				// hold the stalled transaction
			end else if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (pending_requests.size() != 0) begin
				req       <= pending_requests.pop_front();
				req_valid <= 1'b1;
				gap_left  <= quiet ? 0 : idle_length();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall    <= 1'b0;
			hold_left    <= 0;
			long_holds   <= 0;
			results_seen <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_seen <= results_seen + 1;
				if (expected_outcomes.size() == 0) begin
					$error("result transaction with nothing outstanding");
					mismatch_count++;
				end else begin
					rsp_t want;
					want = expected_outcomes.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("granted_virt", want.granted_virt, rsp.granted_virt);
					check_field("granted_len", want.granted_len, rsp.granted_len);
					check_field("first_page", want.first_page, rsp.first_page);
					check_field("page_count", want.page_count, rsp.page_count);
				end
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (long_holds < 2 && results_seen >= PRESSURE_STEP * (long_holds + 1)) begin
				// long hold-off so the block backs up into the request side
				rsp_stall  <= 1'b1;
				hold_left  <= LONG_HOLD;
				long_holds <= long_holds + 1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				hold_left <= idle_length();
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Stimulus sequence
	initial begin
		window_base_model = '0;
		live_map          = '0;
		plan_map          = '0;
		quiet             = 1'b0;
		mismatch_count    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: base 0
		run_phase(32'h0, 0, 1'b0);
		issue_fields(CMD_ALLOC, 32'h0000_0000, 23'h0, 32'h0);          // zero span
		issue_fields(CMD_ALLOC, 32'h0000_0FFF, 23'h2, 32'hFFFF_FFFF);  // crosses a page
		issue_fields(CMD_ALLOC, 32'hFFFF_FFFF, 23'h400000, 32'h0);     // longer than window
		issue_fields(CMD_ALLOC, 32'h0000_1000, 23'h400000, 32'h0);     // whole window, busy
		issue_fields(CMD_FREE, 32'h0, 23'h0, 32'h0);
		issue_fields(CMD_ALLOC, 32'h8000_0123, 23'hF00, 32'h0);        // skips the hole
		issue_fields(CMD_ALLOC, 32'h0000_5000, 23'h1000, 32'h0);       // reuses the hole
		issue_fields(CMD_FREE, 32'h0, 23'h1000, 32'h0000_1ABC);        // misaligned free
		issue_fields(CMD_FREE, 32'h0, 23'h1000, 32'h0000_1ABC);        // already free
		issue_fields(CMD_FREE, 32'h0, 23'h0, 32'h0040_0000);           // past the window
		issue_fields(CMD_FREE, 32'h0, 23'h2000, 32'h003F_F000);        // runs off the end
		issue_fields(CMD_FREE, 32'h0000_07FF, 23'h801, 32'h003F_F7FF); // last page
		issue_fields(CMD_FREE, 32'h0, 23'h400000, 32'h0);
		issue_fields(CMD_ALLOC, 32'h0000_1000, 23'h400000, 32'h0);     // whole window
		issue_fields(CMD_ALLOC, 32'h0, 23'h0, 32'h0);                  // nothing left
		issue_fields(CMD_FREE, 32'h0, 23'h400000, 32'h0);
		issue_fields(CMD_ALLOC, 32'hFFFF_F000, 23'h3FF001, 32'h0);
		issue_fields(CMD_FREE, 32'hFFFF_FFFF, 23'h0, 32'hFFFF_FFFF);
		issue_fields(CMD_FREE, 32'h0, 23'h400000, 32'h0);
		issue_fields(CMD_ALLOC, 32'hFFFF_FFFF, 23'h1, 32'h0);

		// random phases across several bases
		run_phase({20'($urandom_range(0, 32'hFFFFF)), 12'h000}, 300, 1'b0);
		run_phase(32'hFFFF_F000, 250, 1'b1);
		run_phase($urandom_range(0, 32'hFFFF_F000), 300, 1'b0);
		run_phase(32'h0, 300, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_outcomes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cpwa_pkg.sv
hw/rtl/cpwa_bitmap.sv
hw/rtl/contiguous_page_window_allocator.sv
tb/contiguous_page_window_allocator_tb.sv
